// ===== rtl/apu_pkg.sv =====
// Shared types and constants for the Adam parameter update block.
package apu_pkg;

	localparam int DW   = 64;	// serial datapath word
	localparam int DIVW = 34;	// widest divisor

	localparam logic [24:0] ONE_Q24 = 25'd16777216;
	localparam logic [63:0] CAP47   = 64'h0000_7FFF_FFFF_FFFF;
	localparam logic [63:0] CAP48   = 64'h0000_FFFF_FFFF_FFFF;

	localparam logic [1:0] REG_LR  = 2'd0;
	localparam logic [1:0] REG_B1  = 2'd1;
	localparam logic [1:0] REG_B2  = 2'd2;
	localparam logic [1:0] REG_EPS = 2'd3;

	localparam logic [15:0] LR_RST  = 16'd66;
	localparam logic [15:0] B1_RST  = 16'd58982;
	localparam logic [15:0] B2_RST  = 16'd65470;
	localparam logic [15:0] EPS_RST = 16'd1;

	typedef struct packed {
		logic [31:0] m;
		logic [31:0] v;
	} moment_t;

endpackage

// ===== rtl/apu_ram.sv =====
// Generic single write port RAM with registered read.
module apu_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ===== rtl/apu_mul.sv =====
// Bit-serial shift-add multiplier: 64-bit two's complement by 32-bit unsigned.
module apu_mul (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   go,
	input  logic [apu_pkg::DW-1:0] a,
	input  logic [31:0]            b,
	output logic [apu_pkg::DW-1:0] prod,
	output logic                   done
);
	logic                   busy_q;
	logic                   done_q;
	logic [apu_pkg::DW-1:0] mcand_q;
	logic [31:0]            mplier_q;
	logic [apu_pkg::DW-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= !go && busy_q && (mplier_q == '0);
			if (go) begin
				busy_q <= 1'b1;
			end else if (busy_q && mplier_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	// one multiplier bit per cycle; stops once the remaining bits are zero
	always_ff @(posedge clk) begin
		if (go) begin
			mcand_q  <= a;
			mplier_q <= b;
			acc_q    <= '0;
		end else if (busy_q && mplier_q != '0) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= {mcand_q[apu_pkg::DW-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[31:1]};
		end
	end

	assign prod = acc_q;
	assign done = done_q;
endmodule

// ===== rtl/apu_div.sv =====
// Restoring divider, one quotient bit per cycle, 64-bit dividend.
module apu_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     go,
	input  logic [apu_pkg::DW-1:0]   dividend,
	input  logic [apu_pkg::DIVW-1:0] divisor,
	output logic [apu_pkg::DW-1:0]   quo,
	output logic [apu_pkg::DIVW-1:0] rem,
	output logic                     done
);
	logic                     busy_q;
	logic                     done_q;
	logic [5:0]               cnt_q;
	logic [apu_pkg::DW-1:0]   quo_q;
	logic [apu_pkg::DIVW-1:0] rem_q;
	logic [apu_pkg::DIVW-1:0] dsr_q;
	logic [apu_pkg::DIVW:0]   trial;
	logic                     fits;

	assign trial = {rem_q, quo_q[apu_pkg::DW-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !go && busy_q && (cnt_q == 6'd63);
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			// remainder stays below divisor, so the top trial bit drops out
			rem_q <= fits ? apu_pkg::DIVW'(trial - {1'b0, dsr_q})
			              : trial[apu_pkg::DIVW-1:0];
			quo_q <= {quo_q[apu_pkg::DW-2:0], fits};
		end
	end

	assign quo  = quo_q;
	assign rem  = rem_q;
	assign done = done_q;
endmodule

// ===== rtl/apu_sqrt.sv =====
// Digit-by-digit integer square root, two radicand bits per cycle.
module apu_sqrt (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   go,
	input  logic [apu_pkg::DW-1:0] x,
	output logic [31:0]            root,
	output logic                   done
);
	logic                   busy_q;
	logic                   done_q;
	logic [4:0]             cnt_q;
	logic [apu_pkg::DW-1:0] rad_q;
	logic [33:0]            rem_q;
	logic [31:0]            root_q;
	logic [35:0]            cur;
	logic [35:0]            trial;
	logic                   fits;

	assign cur   = {rem_q, rad_q[apu_pkg::DW-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign fits  = cur >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !go && busy_q && (cnt_q == 5'd31);
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rad_q  <= x;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[apu_pkg::DW-3:0], 2'b00};
			rem_q  <= fits ? 34'(cur - trial) : cur[33:0];
			root_q <= {root_q[30:0], fits};
		end
	end

	assign root = root_q;
	assign done = done_q;
endmodule

// ===== rtl/adam_parameter_update.sv =====
// Steps from update item to result: index modulo plus three divisions, a square root and
// six shift-add multiplies (eight on step_start). A correction error skips the divisions,
// the root and the learning rate multiply.
// One item in flight; in_ready rises with out_valid, and the result waits for out_ready.
// Restart items and arst_n run a clearing pass over all NUM_ELEMENTS moment words before in_ready.
// Reset loads default registers and sets both beta powers to one.
module adam_parameter_update #(
	parameter int NUM_ELEMENTS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic        step_start,
	input  logic [9:0]  element_index,
	input  logic signed [31:0] gradient,
	input  logic signed [31:0] param_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [31:0] new_param,
	output logic [9:0]  result_index,
	output logic        no_step_error,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	localparam int AW = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;

	// sequencer states
	localparam logic [4:0] S_CLEAR = 5'd0;
	localparam logic [4:0] S_IDLE  = 5'd1;
	localparam logic [4:0] S_MOD   = 5'd2;	// element index modulo depth
	localparam logic [4:0] S_P1    = 5'd3;	// beta one power advance
	localparam logic [4:0] S_P2    = 5'd4;	// beta two power advance
	localparam logic [4:0] S_RD    = 5'd5;	// moment word available
	localparam logic [4:0] S_M1    = 5'd6;	// b1 * m_old
	localparam logic [4:0] S_M2    = 5'd7;	// (1 - b1) * g
	localparam logic [4:0] S_G2    = 5'd8;	// |g| * |g|
	localparam logic [4:0] S_V1    = 5'd9;	// b2 * v_old
	localparam logic [4:0] S_V2    = 5'd10;	// (1 - b2) * g2
	localparam logic [4:0] S_D1    = 5'd11;	// m_hat division
	localparam logic [4:0] S_D2    = 5'd12;	// v_hat division
	localparam logic [4:0] S_SQ    = 5'd13;	// square root
	localparam logic [4:0] S_D3    = 5'd14;	// m_hat / den
	localparam logic [4:0] S_LR    = 5'd15;	// learning rate scale
	localparam logic [4:0] S_OUT   = 5'd16;	// hand to output register

	logic [4:0]  state_q;
	logic [15:0] lr_q, b1_q, b2_q, eps_q;
	logic [24:0] pw1_q, pw2_q;
	logic        ss_q;
	logic [9:0]  idx_q;
	logic [31:0] g_q, p_q;
	logic [AW-1:0] addr_q, clr_q;
	logic [31:0] m_new_q, v_new_q;
	logic [46:0] mhat_q;
	logic [63:0] acc_q;
	logic [46:0] stp_q;
	logic        err_q;

	logic        out_valid_q;
	logic        out_valid_nx;
	logic [31:0] new_param_q;
	logic [9:0]  result_index_q;
	logic        err_out_q;

	// serial units
	logic        mul_go_q, mul_done;
	logic [63:0] mul_a_q, mul_p;
	logic [31:0] mul_b_q;
	logic        div_go_q, div_done;
	logic [63:0] div_n_q, div_quo;
	logic [33:0] div_d_q, div_rem;
	logic        sq_go_q, sq_done;
	logic [63:0] sq_x_q;
	logic [31:0] sq_root;
	logic        mul_go_nx, div_go_nx, sq_go_nx;

	// moment RAM
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	apu_pkg::moment_t ram_wdata, ram_rdata;

	apu_mul u_mul (
		.clk(clk), .arst_n(arst_n), .go(mul_go_q), .a(mul_a_q), .b(mul_b_q),
		.prod(mul_p), .done(mul_done)
	);

	apu_div u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go_q), .dividend(div_n_q),
		.divisor(div_d_q), .quo(div_quo), .rem(div_rem), .done(div_done)
	);

	apu_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .go(sq_go_q), .x(sq_x_q),
		.root(sq_root), .done(sq_done)
	);

	apu_ram #(.WIDTH(64), .DEPTH(NUM_ELEMENTS)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.re(ram_re), .raddr(ram_raddr), .rdata(ram_rdata)
	);

	// datapath terms
	logic [31:0] g_mag, m_mag;
	logic [24:0] d1, d2;
	logic [63:0] sum64;
	logic signed [63:0] m_sh;
	logic [31:0] m_sat;
	logic [63:0] v_sh;
	logic [31:0] v_sat;
	logic [46:0] mhat_nx;
	logic [47:0] vhat_nx;
	logic [46:0] q_nx;
	logic [32:0] den;
	logic signed [48:0] p_ext, s_ext, np49;
	logic [31:0] np_sat;

	assign g_mag = g_q[31] ? 32'(-g_q) : g_q;
	assign m_mag = m_new_q[31] ? 32'(-m_new_q) : m_new_q;
	assign d1    = apu_pkg::ONE_Q24 - pw1_q;
	assign d2    = apu_pkg::ONE_Q24 - pw2_q;
	assign sum64 = acc_q + mul_p;

	// floor shift then saturate to signed 32
	assign m_sh = $signed(sum64) >>> 16;
	always_comb begin
		if (m_sh > 64'sh7FFF_FFFF) begin
			m_sat = 32'h7FFF_FFFF;
		end else if (m_sh < -64'sh8000_0000) begin
			m_sat = 32'h8000_0000;
		end else begin
			m_sat = m_sh[31:0];
		end
	end

	assign v_sh  = sum64 >> 16;
	assign v_sat = (|v_sh[63:32]) ? 32'hFFFF_FFFF : v_sh[31:0];

	assign mhat_nx = (|div_quo[63:47]) ? apu_pkg::CAP47[46:0] : div_quo[46:0];
	assign vhat_nx = (|div_quo[63:48]) ? apu_pkg::CAP48[47:0] : div_quo[47:0];
	assign q_nx    = (|div_quo[63:47]) ? apu_pkg::CAP47[46:0] : div_quo[46:0];
	assign den     = {1'b0, sq_root} + {17'd0, eps_q};

	// step carries the sign of m; on error or zero den the step is zero
	assign p_ext = {{17{p_q[31]}}, p_q};
	assign s_ext = {2'b00, stp_q};
	assign np49  = m_new_q[31] ? p_ext + s_ext : p_ext - s_ext;
	always_comb begin
		if (np49 > 49'sh7FFF_FFFF) begin
			np_sat = 32'h7FFF_FFFF;
		end else if (np49 < -49'sh8000_0000) begin
			np_sat = 32'h8000_0000;
		end else begin
			np_sat = np49[31:0];
		end
	end

	// start pulses for the serial units, registered so they rise in the cycle after the launching state ends
	always_comb begin
		mul_go_nx = ((state_q == S_MOD) && div_done && ss_q) ||
		            ((state_q == S_P1) && mul_done) ||
		            (state_q == S_RD) ||
		            ((state_q == S_M1) && mul_done) ||
		            ((state_q == S_M2) && mul_done) ||
		            ((state_q == S_G2) && mul_done) ||
		            ((state_q == S_V1) && mul_done) ||
		            ((state_q == S_D3) && div_done);
		div_go_nx = ((state_q == S_IDLE) && in_valid && !func) ||
		            ((state_q == S_V2) && mul_done && (d1 != '0) && (d2 != '0)) ||
		            ((state_q == S_D1) && div_done) ||
		            ((state_q == S_SQ) && sq_done && (den != '0));
		sq_go_nx  = (state_q == S_D2) && div_done;
	end

	// result register loads in S_OUT once the previous result is gone
	always_comb begin
		if ((state_q == S_OUT) && (!out_valid_q || out_ready)) begin
			out_valid_nx = 1'b1;
		end else begin
			out_valid_nx = out_valid_q && !out_ready;
		end
	end

	// RAM access: clearing pass, read after modulo, write back after v
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = '{m: m_new_q, v: v_sat};
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (state_q == S_V2 && mul_done) begin
			ram_we = 1'b1;
		end
	end
	assign ram_re    = (state_q == S_MOD) && div_done;
	assign ram_raddr = div_rem[AW-1:0];

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q  <= apu_pkg::LR_RST;
			b1_q  <= apu_pkg::B1_RST;
			b2_q  <= apu_pkg::B2_RST;
			eps_q <= apu_pkg::EPS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				apu_pkg::REG_LR:  lr_q  <= cfg_data;
				apu_pkg::REG_B1:  b1_q  <= cfg_data;
				apu_pkg::REG_B2:  b2_q  <= cfg_data;
				apu_pkg::REG_EPS: eps_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			pw1_q       <= apu_pkg::ONE_Q24;
			pw2_q       <= apu_pkg::ONE_Q24;
			mul_go_q    <= 1'b0;
			div_go_q    <= 1'b0;
			sq_go_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			mul_go_q    <= mul_go_nx;
			div_go_q    <= div_go_nx;
			sq_go_q     <= sq_go_nx;
			out_valid_q <= out_valid_nx;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(NUM_ELEMENTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						if (func) begin
							pw1_q   <= apu_pkg::ONE_Q24;
							pw2_q   <= apu_pkg::ONE_Q24;
							clr_q   <= '0;
							state_q <= S_CLEAR;
						end else begin
							state_q <= S_MOD;
						end
					end
				end
				S_MOD: begin
					if (div_done) begin
						state_q <= ss_q ? S_P1 : S_RD;
					end
				end
				S_P1: begin
					if (mul_done) begin
						pw1_q   <= mul_p[40:16];
						state_q <= S_P2;
					end
				end
				S_P2: begin
					if (mul_done) begin
						pw2_q   <= mul_p[40:16];
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_M1;
				end
				S_M1: begin
					if (mul_done) begin
						state_q <= S_M2;
					end
				end
				S_M2: begin
					if (mul_done) begin
						state_q <= S_G2;
					end
				end
				S_G2: begin
					if (mul_done) begin
						state_q <= S_V1;
					end
				end
				S_V1: begin
					if (mul_done) begin
						state_q <= S_V2;
					end
				end
				S_V2: begin
					if (mul_done) begin
						if (d1 == '0 || d2 == '0) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_D1;
						end
					end
				end
				S_D1: begin
					if (div_done) begin
						state_q <= S_D2;
					end
				end
				S_D2: begin
					if (div_done) begin
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					if (sq_done) begin
						if (den == '0) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_D3;
						end
					end
				end
				S_D3: begin
					if (div_done) begin
						state_q <= S_LR;
					end
				end
				S_LR: begin
					if (mul_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers and unit operands
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				ss_q    <= step_start;
				idx_q   <= element_index;
				g_q     <= gradient;
				p_q     <= param_value;
				err_q   <= 1'b0;
				div_n_q <= {54'd0, element_index};
				div_d_q <= 34'(NUM_ELEMENTS);
			end
			S_MOD: begin
				addr_q  <= div_rem[AW-1:0];
				mul_a_q <= {39'd0, pw1_q};
				mul_b_q <= {16'd0, b1_q};
			end
			S_P1: begin
				mul_a_q <= {39'd0, pw2_q};
				mul_b_q <= {16'd0, b2_q};
			end
			S_RD: begin
				mul_a_q <= {{32{ram_rdata.m[31]}}, ram_rdata.m};
				mul_b_q <= {16'd0, b1_q};
				v_new_q <= ram_rdata.v;	// old v parked until S_G2
			end
			S_M1: begin
				acc_q   <= mul_p;
				mul_a_q <= {{32{g_q[31]}}, g_q};
				mul_b_q <= 32'(17'h10000 - {1'b0, b1_q});
			end
			S_M2: begin
				m_new_q <= m_sat;
				mul_a_q <= {32'd0, g_mag};
				mul_b_q <= g_mag;
			end
			S_G2: begin
				acc_q   <= {16'd0, mul_p[63:16]};	// g2, multiplicand of the (1 - b2) multiply
				mul_a_q <= {32'd0, v_new_q};
				mul_b_q <= {16'd0, b2_q};
			end
			S_V1: begin
				// g2 stays in acc_q until the b2 * v_old product lands
				if (mul_done) begin
					acc_q   <= mul_p;
					mul_a_q <= acc_q;
				end
				mul_b_q <= 32'(17'h10000 - {1'b0, b2_q});
			end
			S_V2: begin
				v_new_q <= v_sat;
				stp_q   <= '0;
				err_q   <= (d1 == '0) || (d2 == '0);
				div_n_q <= {8'd0, m_mag, 24'd0};
				div_d_q <= {9'd0, d1};
			end
			S_D1: begin
				mhat_q  <= mhat_nx;
				div_n_q <= {8'd0, v_new_q, 24'd0};
				div_d_q <= {9'd0, d2};
			end
			S_D2: begin
				sq_x_q <= {vhat_nx, 16'd0};
			end
			S_SQ: begin
				div_n_q <= {1'b0, mhat_q, 16'd0};
				div_d_q <= {1'b0, den};
			end
			S_D3: begin
				mul_a_q <= {17'd0, q_nx};
				mul_b_q <= {16'd0, lr_q};
			end
			S_LR: begin
				stp_q <= mul_p[62:16];
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					new_param_q    <= np_sat;
					result_index_q <= idx_q;
					err_out_q      <= err_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid     = out_valid_q;
	assign new_param     = new_param_q;
	assign result_index  = result_index_q;
	assign no_step_error = err_out_q;

	// a restart leaves both beta powers at one
	a_restart_pw: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && in_valid && func) |=>
		(pw1_q == apu_pkg::ONE_Q24 && pw2_q == apu_pkg::ONE_Q24))
		else $error("beta powers not reset by restart");

	// moment RAM is written only by the clearing pass or the moment write back
	a_ram_we: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_CLEAR || state_q == S_V2))
		else $error("moment RAM written out of sequence");

	// flagged results carry no step
	a_err_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && err_q) |-> (stp_q == '0))
		else $error("step nonzero on correction error");

	// a new result only appears out of the hand-off state
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == S_OUT)
		else $error("result raised outside hand-off");
endmodule
